[rtl/core/pid_duty_controller_assert.svh]
// Assertion macros for the PID duty controller core.
// Used by rtl/core/pid_duty_controller.sv; expects clk_i and rst_ni in scope.
`ifndef PID_DUTY_CONTROLLER_ASSERT_SVH
`define PID_DUTY_CONTROLLER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define PDC_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pdc_pkg.sv]
// Types and constants of the PID duty controller.
// No dependencies; imported by rtl/core/pid_duty_controller.sv.
`default_nettype none

package pdc_pkg;

  localparam int unsigned GainW  = 16;
  localparam int unsigned TempW  = 16;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // error = setpoint - measured, one bit wider than a temperature
  localparam int unsigned ErrW   = TempW + 1;
  localparam int unsigned DeltaW = ErrW + 1;
  localparam int unsigned SumW   = 32;
  // drive in units of 2^-13; duty is drive >> 13
  localparam int unsigned FracW  = 13;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  localparam logic [DutyW-1:0] DutyLimitReset = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_SETPOINT   = 3'd3,
    REG_DUTY_LIMIT = 3'd4
  } pdc_reg_e;

endpackage

`default_nettype wire

[rtl/core/pid_duty_controller.sv]
// PID heater duty controller with conditional-integration anti-windup.
// Depends on rtl/core/pdc_pkg.sv and rtl/core/pid_duty_controller_assert.svh.
//
// One measured temperature in, one duty and held flag out. A new item is
// taken every cycle unless the output stalls, through the input register,
// product, term-add and result stages. The error sum and its product with
// the integral gain are carried as state in the result stage and updated
// there in the same cycle, so items follow one another with no gap. Gains,
// setpoint and limit are written through the write port while the block is
// idle, a rule for the user not enforced by the block; after an integral
// gain write the stored product is rebuilt by a 16x32 multiplier when idle.
`default_nettype none

module pid_duty_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              cfg_we_i,
  input  wire logic [pdc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [pdc_pkg::CfgDataW-1:0]      cfg_data_i,

  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic signed [pdc_pkg::TempW-1:0]  measured_temp_i,

  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [pdc_pkg::DutyW-1:0]         duty_o,
  output      logic                              integ_held_o
);

  import pdc_pkg::*;

  `include "pid_duty_controller_assert.svh"

  localparam int unsigned PW = GainW + SumW + 1;      // ki * sum
  localparam int unsigned PpW = GainW + 1 + ErrW;     // kp * e
  localparam int unsigned PdW = GainW + 1 + DeltaW;   // kd * de
  localparam int unsigned AW = PdW + 3;               // 2kp*e + 4kd*de
  localparam int unsigned TW = PW + 1;                // full drive

  // configuration registers
  logic [GainW-1:0]        gain_prop_q, gain_integ_q, gain_deriv_q;
  logic signed [TempW-1:0] setpoint_q;
  logic [DutyW-1:0]        duty_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      setpoint_q   <= '0;
      duty_limit_q <= DutyLimitReset;
    end else if (cfg_we_i) begin
      unique case (pdc_reg_e'(cfg_index_i))
        REG_GAIN_PROP:  gain_prop_q  <= cfg_data_i[GainW-1:0];
        REG_GAIN_INTEG: gain_integ_q <= cfg_data_i[GainW-1:0];
        REG_GAIN_DERIV: gain_deriv_q <= cfg_data_i[GainW-1:0];
        REG_SETPOINT:   setpoint_q   <= $signed(cfg_data_i[TempW-1:0]);
        REG_DUTY_LIMIT: duty_limit_q <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic v0_q, v1_q, v2_q, ov_q;
  logic take1, take2, take3;

  assign take3      = v2_q && (!ov_q || out_ready_i);
  assign take2      = v1_q && (!v2_q || take3);
  assign take1      = v0_q && (!v1_q || take2);
  assign in_ready_o = !v0_q || take1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (in_ready_o) v0_q <= in_valid_i;
      if (!v1_q || take2) v1_q <= take1;
      if (!v2_q || take3) v2_q <= take2;
      if (!ov_q || out_ready_i) ov_q <= take3;
    end
  end

  // input register
  logic signed [TempW-1:0] meas0_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) meas0_q <= measured_temp_i;
  end

  // product stage: error, its difference, and the three gain products
  logic signed [ErrW-1:0]   e_d, last_e_q, e1_q;
  logic signed [DeltaW-1:0] de_d;
  logic signed [GainW:0]    kp_s, ki_s, kd_s;
  logic signed [PpW-1:0]    pp_d, pp1_q;
  logic signed [PdW-1:0]    pd_d, pd1_q;
  logic signed [PpW-1:0]    ke_d, ke1_q;

  assign kp_s = $signed({1'b0, gain_prop_q});
  assign ki_s = $signed({1'b0, gain_integ_q});
  assign kd_s = $signed({1'b0, gain_deriv_q});

  assign e_d  = ErrW'(setpoint_q) - ErrW'(meas0_q);
  assign de_d = DeltaW'(e_d) - DeltaW'(last_e_q);
  assign pp_d = PpW'(kp_s) * PpW'(e_d);
  assign pd_d = PdW'(kd_s) * PdW'(de_d);
  assign ke_d = PpW'(ki_s) * PpW'(e_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_e_q <= '0;
    end else if (take1) begin
      last_e_q <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1) begin
      e1_q  <= e_d;
      pp1_q <= pp_d;
      pd1_q <= pd_d;
      ke1_q <= ke_d;
    end
  end

  // term-add stage: everything that does not depend on the error sum
  logic signed [ErrW-1:0] e2_q;
  logic signed [AW-1:0]   a2_q;
  logic signed [PpW-1:0]  ke2_q;

  always_ff @(posedge clk_i) begin
    if (take2) begin
      e2_q  <= e1_q;
      a2_q  <= (AW'(pp1_q) <<< 1) + (AW'(pd1_q) <<< 2);
      ke2_q <= ke1_q;
    end
  end

  // result stage: error sum state, anti-windup decision, clamp
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [PW-1:0]   p_q, p_d;      // holds gain_integ * sum
  logic [DutyW-1:0]       duty_d, duty_q;
  logic                   held_d, held_q;

  always_comb begin
    logic signed [SumW:0]   sum_raw;
    logic signed [SumW-1:0] sum_sat;
    logic signed [PW-1:0]   ki_w, p_new;
    logic signed [TW-1:0]   t_new, t_old, t_sel, thresh;
    logic                   ovf, unf;

    sum_raw = (SumW+1)'(sum_q) + (SumW+1)'(e2_q);
    ovf     = !sum_raw[SumW] && sum_raw[SumW-1];
    unf     = sum_raw[SumW] && !sum_raw[SumW-1];
    ki_w    = $signed({{(PW-GainW){1'b0}}, gain_integ_q});

    if (ovf) begin
      sum_sat = SumMax;
      p_new   = (ki_w <<< (SumW-1)) - ki_w;
    end else if (unf) begin
      sum_sat = SumMin;
      p_new   = -(ki_w <<< (SumW-1));
    end else begin
      sum_sat = sum_raw[SumW-1:0];
      p_new   = p_q + PW'(ke2_q);
    end

    thresh = $signed({{(TW-DutyW-FracW){1'b0}}, duty_limit_q, {FracW{1'b0}}});
    t_new  = TW'(a2_q) + TW'(p_new);
    t_old  = TW'(a2_q) + TW'(p_q);
    held_d = t_new > thresh;
    t_sel  = held_d ? t_old : t_new;

    if (t_sel < 0) begin
      duty_d = '0;
    end else if (t_sel > thresh) begin
      duty_d = duty_limit_q;
    end else begin
      duty_d = t_sel[FracW +: DutyW];
    end

    // withdraw the increment when the drive overshoots the limit
    if (take3) begin
      sum_d = held_d ? sum_q : sum_sat;
      p_d   = held_d ? p_q : p_new;
    end else begin
      // rebuild the product while idle so a gain write is picked up
      sum_d = sum_q;
      p_d   = PW'(ki_s) * PW'(sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      p_q   <= '0;
    end else begin
      sum_q <= sum_d;
      p_q   <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take3) begin
      duty_q <= duty_d;
      held_q <= held_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign duty_o       = duty_q;
  assign integ_held_o = held_q;

  `PDC_ASSERT(a_duty_in_limit, !ov_q || (duty_q <= duty_limit_q), "duty above limit")
  `PDC_ASSERT_NEXT(a_held_keeps_sum, take3 && held_d, sum_q == $past(sum_q),
                   "error sum moved on a held tick")
  `PDC_ASSERT_NEXT(a_result_from_stage, !v2_q, !$rose(ov_q), "result without an item")

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the PID duty controller.
// Depends on rtl/core/pdc_pkg.sv and the pid_duty_controller top level.
// Directed table, random phases at three idle profiles, and a long hold-off.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdc_pkg::*;

  localparam int ClkHalf       = 10;
  localparam int ResetCycles   = 7;
  localparam int DrainCycles   = 8;
  localparam int LongHold      = 300;
  localparam int PhaseItems    = 200;
  localparam int NumPhases     = 6;
  localparam longint TimeoutNs = 64'd60_000_000;

  localparam logic [CfgIdxW-1:0] RegUnmapped5 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnmapped6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnmapped7 = 3'd7;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             held;
  } duty_res_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_TEMP,
    ROW_TEMP_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [TempW-1:0]    temp;
    logic [DutyW-1:0]    duty;
    logic                held;
  } dir_row_t;

  localparam int NumDirRows = 37;

  dir_row_t dir_rows [NumDirRows] = '{
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h8000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h7FFF, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_GAIN_PROP,  16'hFFFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h8000, 8'd255, 1'b1},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h7FFF, 8'd0,   1'b0},
    // zero limit: any positive drive is held at zero duty
    '{ROW_WRITE,      REG_DUTY_LIMIT, 16'h0000, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'hFFFF, 8'd0,   1'b1},
    '{ROW_WRITE,      REG_GAIN_PROP,  16'h0100, 16'h0000, 8'd0,   1'b0},
    // upper byte must be dropped, leaving a limit of 255
    '{ROW_WRITE,      REG_DUTY_LIMIT, 16'h12FF, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'hFF60, 8'd10,  1'b0},
    '{ROW_WRITE,      RegUnmapped5,   16'hFFFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      RegUnmapped6,   16'hFFFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      RegUnmapped7,   16'h7FFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'hFF60, 8'd10,  1'b0},
    '{ROW_WRITE,      REG_SETPOINT,   16'h7FFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h8000, 8'd255, 1'b1},
    '{ROW_WRITE,      REG_SETPOINT,   16'h8000, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP_KNOWN, '0,             16'h0000, 16'h7FFF, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_GAIN_INTEG, 16'h0200, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_GAIN_DERIV, 16'h0100, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_SETPOINT,   16'h0140, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_DUTY_LIMIT, 16'h00C8, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h0100, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h0140, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h0180, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h0140, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h0120, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_GAIN_PROP,  16'hFFFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_GAIN_INTEG, 16'hFFFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_GAIN_DERIV, 16'hFFFF, 16'h0000, 8'd0,   1'b0},
    '{ROW_WRITE,      REG_DUTY_LIMIT, 16'h00FF, 16'h0000, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h8000, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h7FFF, 8'd0,   1'b0},
    '{ROW_TEMP,       '0,             16'h0000, 16'h0140, 8'd0,   1'b0}
  };

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i     = '0;
  logic [CfgDataW-1:0]     cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_ready_o;
  logic signed [TempW-1:0] measured_temp_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i     = 1'b0;
  logic [DutyW-1:0]        duty_o;
  logic                    integ_held_o;

  // controller copy: registers and state
  logic [GainW-1:0]        ctl_kp;
  logic [GainW-1:0]        ctl_ki;
  logic [GainW-1:0]        ctl_kd;
  logic signed [TempW-1:0] ctl_setpoint;
  logic [DutyW-1:0]        ctl_limit;
  logic signed [SumW-1:0]  ctl_err_sum;
  logic signed [ErrW-1:0]  ctl_last_err;

  duty_res_t pending_duty [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int stall_reqs    = 0;
  int stall_served  = 0;
  int hold_left     = 0;
  int err_count     = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int writes_done   = 0;
  int held_seen     = 0;

  pid_duty_controller u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .measured_temp_i(measured_temp_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .duty_o         (duty_o),
    .integ_held_o   (integ_held_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  initial begin
    #(TimeoutNs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // drive term in units of 2^-13
  function automatic longint drive_term(longint e, longint sum, longint de);
    return 2 * longint'(ctl_kp) * e + longint'(ctl_ki) * sum + 4 * longint'(ctl_kd) * de;
  endfunction

  function automatic duty_res_t predict_duty(input logic signed [TempW-1:0] temp);
    longint    e;
    longint    de;
    longint    old_sum;
    longint    new_sum;
    longint    thresh;
    longint    t;
    duty_res_t res;
    e       = longint'(ctl_setpoint) - longint'(temp);
    de      = e - longint'(ctl_last_err);
    old_sum = longint'(ctl_err_sum);
    new_sum = old_sum + e;
    thresh  = longint'(ctl_limit) * 8192;
    res     = '0;
    if (new_sum > longint'(SumMax)) new_sum = longint'(SumMax);
    if (new_sum < longint'(SumMin)) new_sum = longint'(SumMin);
    t = drive_term(e, new_sum, de);
    // withdraw this tick's increment when the drive overshoots the limit
    if (t > thresh) begin
      new_sum  = old_sum;
      t        = drive_term(e, new_sum, de);
      res.held = 1'b1;
    end
    if (t < 0) begin
      res.duty = '0;
    end else if (t > thresh) begin
      res.duty = ctl_limit;
    end else begin
      res.duty = DutyW'(t >>> FracW);
    end
    ctl_err_sum  = SumW'(new_sum);
    ctl_last_err = ErrW'(e);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // caller lowers cfg_we_i after the last write of a batch
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_GAIN_PROP:  ctl_kp       = data;
      REG_GAIN_INTEG: ctl_ki       = data;
      REG_GAIN_DERIV: ctl_kd       = data;
      REG_SETPOINT:   ctl_setpoint = data;
      REG_DUTY_LIMIT: ctl_limit    = data[DutyW-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic send_temp(input logic signed [TempW-1:0] temp, input bit typed,
                           input duty_res_t typed_res);
    duty_res_t res;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid_i      <= 1'b1;
    measured_temp_i <= temp;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_duty(temp);
    pending_duty.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // hold the input until every result is back; settle before a register write
  task automatic wait_idle(input bit settle);
    in_valid_i <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk_i);
    if (settle) repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GainW'($urandom);
      default: return GainW'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic signed [TempW-1:0] pick_temp();
    int v;
    case ($urandom_range(0, 9))
      0, 1:    return TempW'($urandom);
      2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: begin
        v = int'(ctl_setpoint) + int'($urandom_range(0, 2048)) - 1024;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return TempW'(v);
      end
    endcase
  endfunction

  // receiver: random back-pressure plus a single long hold-off
  always @(posedge clk_i) begin
    if (hold_left == 0 && stall_served != stall_reqs) begin
      stall_served = stall_reqs;
      hold_left    = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    duty_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (integ_held_o) held_seen++;
      if (pending_duty.size() == 0) begin
        report_mismatch("unexpected item, duty", duty_o, -1);
      end else begin
        want = pending_duty.pop_front();
        if (duty_o !== want.duty) report_mismatch("duty", duty_o, want.duty);
        if (integ_held_o !== want.held) report_mismatch("integ_held", integ_held_o, want.held);
      end
    end
  end

  initial begin
    duty_res_t typed_res;
    logic [GainW-1:0] kp_new;
    logic [GainW-1:0] ki_new;
    logic [GainW-1:0] kd_new;
    logic [DutyW-1:0] lim_new;
    logic [TempW-1:0] sp_new;

    ctl_kp       = '0;
    ctl_ki       = '0;
    ctl_kd       = '0;
    ctl_setpoint = '0;
    ctl_limit    = DutyLimitReset;
    ctl_err_sum  = '0;
    ctl_last_err = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        if (r == 0 || dir_rows[r-1].kind != ROW_WRITE) wait_idle(1'b1);
        write_reg(dir_rows[r].idx, dir_rows[r].data);
        if (r == NumDirRows - 1 || dir_rows[r+1].kind != ROW_WRITE) cfg_we_i <= 1'b0;
      end else begin
        typed_res.duty = dir_rows[r].duty;
        typed_res.held = dir_rows[r].held;
        send_temp(dir_rows[r].temp, dir_rows[r].kind == ROW_TEMP_KNOWN, typed_res);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      kp_new  = pick_gain();
      ki_new  = pick_gain();
      kd_new  = pick_gain();
      lim_new = DutyW'($urandom_range(1, 254));
      case ($urandom_range(0, 5))
        0:       sp_new = 16'h7FFF;
        1:       sp_new = 16'h8000;
        default: sp_new = TempW'($urandom_range(0, 1600));
      endcase
      // one phase at the largest proportional and derivative gains and limit, one at the zero limit
      if (ph == 1) begin
        kp_new  = '1;
        kd_new  = '1;
        lim_new = '1;
      end
      if (ph == 2) lim_new = '0;
      wait_idle(1'b1);
      write_reg(REG_GAIN_PROP, kp_new);
      write_reg(REG_GAIN_INTEG, ki_new);
      write_reg(REG_GAIN_DERIV, kd_new);
      write_reg(REG_SETPOINT, sp_new);
      write_reg(REG_DUTY_LIMIT, CfgDataW'($urandom_range(0, 255) << DutyW) | lim_new);
      cfg_we_i <= 1'b0;
      if (ph < 2) begin
        src_idle_pct  = 24;
        sink_idle_pct = 52;
      end else if (ph < 4) begin
        src_idle_pct  = 52;
        sink_idle_pct = 24;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 4 && i == 40) stall_reqs++;
        if (ph == 4 && i == 120) wait_idle(1'b0);
        send_temp(pick_temp(), 1'b0, '0);
      end
    end

    wait_idle(1'b1);

    $display("Run covered %0d items, %0d results (%0d held) and %0d register writes,",
             items_sent, results_seen, held_seen, writes_done);
    $display("over three idle profiles, a long output hold-off and a zero duty limit.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
